@@ rtl/tac_pkg.sv @@
`default_nettype none

package tac_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned SCALE_W    = 17;
  localparam int unsigned OFFSET_W   = 17;
  localparam int unsigned OUT_W      = 32;
  localparam int unsigned MAG_W      = 32;
  localparam int unsigned DIV_W      = 11;
  localparam int unsigned SCOUNT_W   = 11;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned CNT_LIMIT  = 2047;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_SAMPLE_COUNT     = 3'd0;
  localparam cfg_idx_t REG_IS_ACCELEROMETER = 3'd1;
  localparam cfg_idx_t REG_CORRECTION_MODE  = 3'd2;
  localparam cfg_idx_t REG_SCALE_X          = 3'd3;
  localparam cfg_idx_t REG_SCALE_Y          = 3'd4;
  localparam cfg_idx_t REG_SCALE_Z          = 3'd5;
  localparam cfg_idx_t REG_LOADED_VALID     = 3'd6;

  localparam logic [SCOUNT_W-1:0]       SAMPLE_COUNT_RST = 11'd64;
  localparam logic signed [SCALE_W-1:0] SCALE_RST        = 17'sd1000;
  localparam logic signed [OUT_W-1:0]   ONE_G_MG         = 32'sd1000;
  localparam logic [DIV_W-1:0]          PER_MILLE        = 11'd1000;

  typedef enum logic [1:0] {
    STATUS_APPLIED  = 2'd0,
    STATUS_UNCAL    = 2'd1,
    STATUS_CAL_DONE = 2'd2,
    STATUS_CAL_FAIL = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_MUL_GO,
    S_MUL_WAIT,
    S_DIV_GO,
    S_DIV_WAIT,
    S_RESULT
  } state_e;

endpackage

`default_nettype wire

@@ rtl/tac_if.sv @@
`default_nettype none

interface tac_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic        sample_ok;
  logic signed [15:0] sample_x;
  logic signed [15:0] sample_y;
  logic signed [15:0] sample_z;

  modport source (output valid, mode, sample_ok, sample_x, sample_y, sample_z, input ready);
  modport sink   (input valid, mode, sample_ok, sample_x, sample_y, sample_z, output ready);
endinterface

interface tac_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;

  modport source (output valid, status, out_x, out_y, out_z, input ready);
  modport sink   (input valid, status, out_x, out_y, out_z, output ready);
endinterface

interface tac_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [16:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/tac_accum.sv @@
`default_nettype none

module tac_accum #(
  parameter int unsigned CNT_W = 11,
  parameter int unsigned SUM_W = 27
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              add_i,
  input  wire logic                              ok_i,
  input  wire logic signed [tac_pkg::SAMPLE_W-1:0] sample_i [3],
  input  wire logic                              clr_i,
  output logic signed [SUM_W-1:0]                sum_o [3],
  output logic [CNT_W-1:0]                       taken_o,
  output logic [CNT_W-1:0]                       good_o
);

  logic signed [SUM_W-1:0] sum_q [3];
  logic [CNT_W-1:0]        taken_q;
  logic [CNT_W-1:0]        good_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        sum_q[i] <= '0;
      end
      taken_q <= '0;
      good_q  <= '0;
    end else if (clr_i) begin
      for (int i = 0; i < 3; i++) begin
        sum_q[i] <= '0;
      end
      taken_q <= '0;
      good_q  <= '0;
    end else if (add_i) begin
      taken_q <= taken_q + 1'b1;
      if (ok_i) begin
        for (int i = 0; i < 3; i++) begin
          sum_q[i] <= sum_q[i] + SUM_W'(sample_i[i]);
        end
        good_q <= good_q + 1'b1;
      end
    end
  end

  assign sum_o   = sum_q;
  assign taken_o = taken_q;
  assign good_o  = good_q;

endmodule

`default_nettype wire

@@ rtl/tac_sermul.sv @@
`default_nettype none

module tac_sermul (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [tac_pkg::SCALE_W-1:0]  a_i,
  input  wire logic [tac_pkg::SCALE_W-1:0]  b_i,
  output logic                              done_o,
  output logic [tac_pkg::MAG_W-1:0]         product_o
);

  localparam int unsigned OP_W  = tac_pkg::SCALE_W;
  localparam int unsigned CNT_W = $clog2(OP_W + 1);

  logic [OP_W-1:0]   a_q;
  logic [2*OP_W-1:0] p_q;
  logic [2*OP_W-1:0] p_d;
  logic [OP_W:0]     upper;
  logic [CNT_W-1:0]  cnt_q;
  logic              done_q;

  // One multiplier bit per cycle: add the multiplicand to the upper half, then shift right.
  always_comb begin
    upper = {1'b0, p_q[2*OP_W-1:OP_W]} + (p_q[0] ? {1'b0, a_q} : '0);
    p_d   = {upper, p_q[OP_W-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CNT_W'(1));
      if (start_i) begin
        cnt_q <= CNT_W'(OP_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      p_q <= {{OP_W{1'b0}}, b_i};
    end else if (cnt_q != '0) begin
      p_q <= p_d;
    end
  end

  assign done_o    = done_q;
  assign product_o = p_q[tac_pkg::MAG_W-1:0];

endmodule

`default_nettype wire

@@ rtl/tac_serdiv.sv @@
`default_nettype none

module tac_serdiv (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [tac_pkg::MAG_W-1:0]     mag_i,
  input  wire logic                          neg_i,
  input  wire logic [tac_pkg::DIV_W-1:0]     den_i,
  output logic                               done_o,
  output logic signed [tac_pkg::MAG_W-1:0]   quot_o
);

  localparam int unsigned MAG_W = tac_pkg::MAG_W;
  localparam int unsigned DEN_W = tac_pkg::DIV_W;
  localparam int unsigned CNT_W = $clog2(MAG_W + 1);

  logic [MAG_W-1:0] q_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic             neg_q;
  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   diff;
  logic             ge;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    rem_sh = {rem_q, q_q[MAG_W-1]};
    diff   = rem_sh - {1'b0, den_q};
    ge     = !diff[DEN_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CNT_W'(1));
      if (start_i) begin
        cnt_q <= CNT_W'(MAG_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= mag_i;
      rem_q <= '0;
      den_q <= den_i;
      neg_q <= neg_i;
    end else if (cnt_q != '0) begin
      q_q   <= {q_q[MAG_W-2:0], ge};
      rem_q <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? (MAG_W'(0) - q_q) : q_q;

endmodule

`default_nettype wire

@@ rtl/three_axis_offset_calibrator.sv @@
`default_nettype none

// Three-axis offset and scale calibrator.
// Samples arrive on in_ch, results leave on out_ch, and registers are written on cfg_ch,
// which is always ready and should be written only while the block is idle.
// A calibration sample (mode 0) is counted and, if ok, summed; the sample that completes a
// run produces one result with the new offsets (status 2) or a failure (status 3).
// An apply sample (mode 1) always produces one result: the sample unchanged (status 1),
// the sample minus the stored offsets, or the sample scaled per mille (status 0).
// One item is in flight at a time. A calibration sample that does not end a run passes
// through the decode state back to idle, an unchanged or offset-corrected sample through
// decode and result to the output register. The end of a run uses three divisions, one
// per axis, in one shared bit-serial divider. A scaled sample takes per axis a
// bit-serial multiply followed by a division by 1000.
// The output register holds a finished result while the receiver stalls; the next
// sample is still taken and worked on, and its result waits until the register frees.
// Reset clears the run, the offsets and the calibrated flag and loads the register
// defaults; no clearing pass is needed.
module three_axis_offset_calibrator #(
  parameter int unsigned MAX_SAMPLES = 1024
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tac_in_if.sink     in_ch,
  tac_out_if.source  out_ch,
  tac_cfg_if.sink    cfg_ch
);

  localparam int unsigned SAMPLE_W = tac_pkg::SAMPLE_W;
  localparam int unsigned SCALE_W  = tac_pkg::SCALE_W;
  localparam int unsigned OFFSET_W = tac_pkg::OFFSET_W;
  localparam int unsigned OUT_W    = tac_pkg::OUT_W;
  localparam int unsigned MAG_W    = tac_pkg::MAG_W;
  localparam int unsigned DIV_W    = tac_pkg::DIV_W;
  localparam int unsigned SCOUNT_W = tac_pkg::SCOUNT_W;
  localparam int unsigned NMAX     =
      (MAX_SAMPLES < tac_pkg::CNT_LIMIT) ? MAX_SAMPLES : tac_pkg::CNT_LIMIT;
  localparam int unsigned CNT_W    = $clog2(NMAX + 1);
  localparam int unsigned SUM_W    = SAMPLE_W + CNT_W;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Configuration registers.
  logic [SCOUNT_W-1:0]       sample_count_q;
  logic                      is_accel_q;
  logic                      corr_mode_q;
  logic signed [SCALE_W-1:0] scale_q [3];
  logic                      loaded_valid_q;

  // Calibration state.
  logic signed [OFFSET_W-1:0] offset_q [3];
  logic                       calibrated_q;

  // Item in flight and result.
  tac_pkg::state_e            state_q, state_d;
  logic                       mode_q;
  logic signed [SAMPLE_W-1:0] sample_q [3];
  logic [1:0]                 axis_q;
  tac_pkg::status_e           status_q;
  logic signed [OUT_W-1:0]    res_q [3];

  logic                       out_valid_q;
  logic [1:0]                 out_status_q;
  logic signed [OUT_W-1:0]    out_x_q, out_y_q, out_z_q;

  // Control strobes.
  logic in_ready, mul_start, div_start, out_load, run_clr;

  // Accumulator.
  logic signed [SAMPLE_W-1:0] in_sample [3];
  logic signed [SUM_W-1:0]    sum [3];
  logic [CNT_W-1:0]           taken_cnt, good_cnt;

  // Run decision.
  logic [CNT_W-1:0] run_len;
  logic             run_end, run_fail, cal_ok;

  // Arithmetic units.
  logic signed [SCALE_W-1:0] smp_ext;
  logic [SCALE_W-1:0]        mul_a, mul_b;
  logic                      mul_neg_q;
  logic                      mul_done;
  logic [MAG_W-1:0]          product;
  logic signed [MAG_W-1:0]   sum_ext;
  logic [MAG_W-1:0]          div_mag;
  logic                      div_neg;
  logic [DIV_W-1:0]          div_den;
  logic                      div_done;
  logic signed [MAG_W-1:0]   quot;
  logic signed [OUT_W-1:0]   z_offset;

  assign in_sample[0] = in_ch.sample_x;
  assign in_sample[1] = in_ch.sample_y;
  assign in_sample[2] = in_ch.sample_z;

  tac_accum #(
    .CNT_W (CNT_W),
    .SUM_W (SUM_W)
  ) u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .add_i    (in_ch.valid && in_ready && !in_ch.mode),
    .ok_i     (in_ch.sample_ok),
    .sample_i (in_sample),
    .clr_i    (run_clr),
    .sum_o    (sum),
    .taken_o  (taken_cnt),
    .good_o   (good_cnt)
  );

  always_comb begin
    if (sample_count_q == '0) begin
      run_len = CNT_W'(1);
    end else if (32'(sample_count_q) > NMAX) begin
      run_len = CNT_W'(NMAX);
    end else begin
      run_len = CNT_W'(sample_count_q);
    end
  end

  assign run_end  = (taken_cnt >= run_len);
  assign run_fail = (good_cnt == '0) || (good_cnt < (run_len >> 1));
  assign cal_ok   = calibrated_q || loaded_valid_q;

  // Operands for the current axis.
  assign smp_ext = SCALE_W'(sample_q[axis_q]);
  assign mul_a   = smp_ext[SCALE_W-1] ? (~smp_ext + 1'b1) : smp_ext;
  assign mul_b   = scale_q[axis_q][SCALE_W-1] ? (~scale_q[axis_q] + 1'b1) : scale_q[axis_q];
  assign sum_ext = MAG_W'(sum[axis_q]);

  always_comb begin
    if (!mode_q) begin
      div_mag = sum_ext[MAG_W-1] ? (~sum_ext + 1'b1) : sum_ext;
      div_neg = sum_ext[MAG_W-1];
      div_den = DIV_W'(good_cnt);
    end else begin
      div_mag = product;
      div_neg = mul_neg_q;
      div_den = tac_pkg::PER_MILLE;
    end
  end

  tac_sermul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .a_i       (mul_a),
    .b_i       (mul_b),
    .done_o    (mul_done),
    .product_o (product)
  );

  tac_serdiv u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .mag_i   (div_mag),
    .neg_i   (div_neg),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  assign z_offset = quot - (is_accel_q ? tac_pkg::ONE_G_MG : '0);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tac_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          state_d = tac_pkg::S_DECODE;
        end
      end
      tac_pkg::S_DECODE: begin
        if (!mode_q) begin
          if (!run_end) begin
            state_d = tac_pkg::S_IDLE;
          end else if (run_fail) begin
            state_d = tac_pkg::S_RESULT;
          end else begin
            state_d = tac_pkg::S_DIV_GO;
          end
        end else if (!cal_ok || !corr_mode_q) begin
          state_d = tac_pkg::S_RESULT;
        end else begin
          state_d = tac_pkg::S_MUL_GO;
        end
      end
      tac_pkg::S_MUL_GO: state_d = tac_pkg::S_MUL_WAIT;
      tac_pkg::S_MUL_WAIT: begin
        if (mul_done) begin
          state_d = tac_pkg::S_DIV_GO;
        end
      end
      tac_pkg::S_DIV_GO: state_d = tac_pkg::S_DIV_WAIT;
      tac_pkg::S_DIV_WAIT: begin
        if (div_done) begin
          if (axis_q == AXIS_Z) begin
            state_d = tac_pkg::S_RESULT;
          end else if (!mode_q) begin
            state_d = tac_pkg::S_DIV_GO;
          end else begin
            state_d = tac_pkg::S_MUL_GO;
          end
        end
      end
      tac_pkg::S_RESULT: begin
        if (out_load) begin
          state_d = tac_pkg::S_IDLE;
        end
      end
      default: state_d = tac_pkg::S_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_ready  = (state_q == tac_pkg::S_IDLE);
    mul_start = (state_q == tac_pkg::S_MUL_GO);
    div_start = (state_q == tac_pkg::S_DIV_GO);
    out_load  = (state_q == tac_pkg::S_RESULT) && (!out_valid_q || out_ch.ready);
    run_clr   = ((state_q == tac_pkg::S_DECODE) && !mode_q && run_end && run_fail) ||
                ((state_q == tac_pkg::S_DIV_WAIT) && div_done && !mode_q &&
                 (axis_q == AXIS_Z));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tac_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q <= tac_pkg::SAMPLE_COUNT_RST;
      is_accel_q     <= 1'b0;
      corr_mode_q    <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        scale_q[i] <= tac_pkg::SCALE_RST;
      end
      loaded_valid_q <= 1'b0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        tac_pkg::REG_SAMPLE_COUNT:     sample_count_q <= cfg_ch.data[SCOUNT_W-1:0];
        tac_pkg::REG_IS_ACCELEROMETER: is_accel_q     <= cfg_ch.data[0];
        tac_pkg::REG_CORRECTION_MODE:  corr_mode_q    <= cfg_ch.data[0];
        tac_pkg::REG_SCALE_X:          scale_q[0]     <= cfg_ch.data[SCALE_W-1:0];
        tac_pkg::REG_SCALE_Y:          scale_q[1]     <= cfg_ch.data[SCALE_W-1:0];
        tac_pkg::REG_SCALE_Z:          scale_q[2]     <= cfg_ch.data[SCALE_W-1:0];
        tac_pkg::REG_LOADED_VALID:     loaded_valid_q <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  assign cfg_ch.ready = 1'b1;

  // Control state of the item in flight and the calibration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q       <= AXIS_X;
      calibrated_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        offset_q[i] <= '0;
      end
      out_valid_q  <= 1'b0;
    end else begin
      if (state_q == tac_pkg::S_DECODE) begin
        axis_q <= AXIS_X;
      end else if ((state_q == tac_pkg::S_DIV_WAIT) && div_done) begin
        axis_q <= axis_q + 1'b1;
        if (!mode_q && (axis_q == AXIS_Z)) begin
          offset_q[0]  <= OFFSET_W'(res_q[0]);
          offset_q[1]  <= OFFSET_W'(res_q[1]);
          offset_q[2]  <= OFFSET_W'(z_offset);
          calibrated_q <= 1'b1;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ready) begin
      mode_q      <= in_ch.mode;
      sample_q[0] <= in_ch.sample_x;
      sample_q[1] <= in_ch.sample_y;
      sample_q[2] <= in_ch.sample_z;
    end
    if (mul_start) begin
      mul_neg_q <= smp_ext[SCALE_W-1] ^ scale_q[axis_q][SCALE_W-1];
    end
    if (state_q == tac_pkg::S_DECODE) begin
      if (!mode_q) begin
        status_q <= run_fail ? tac_pkg::STATUS_CAL_FAIL : tac_pkg::STATUS_CAL_DONE;
        for (int i = 0; i < 3; i++) begin
          res_q[i] <= '0;
        end
      end else if (!cal_ok) begin
        status_q <= tac_pkg::STATUS_UNCAL;
        for (int i = 0; i < 3; i++) begin
          res_q[i] <= OUT_W'(sample_q[i]);
        end
      end else begin
        status_q <= tac_pkg::STATUS_APPLIED;
        for (int i = 0; i < 3; i++) begin
          res_q[i] <= OUT_W'(sample_q[i]) - OUT_W'(offset_q[i]);
        end
      end
    end else if ((state_q == tac_pkg::S_DIV_WAIT) && div_done) begin
      res_q[axis_q] <= (!mode_q && (axis_q == AXIS_Z)) ? z_offset : quot;
    end
    if (out_load) begin
      out_status_q <= status_q;
      out_x_q      <= res_q[0];
      out_y_q      <= res_q[1];
      out_z_q      <= res_q[2];
    end
  end

  assign in_ch.ready   = in_ready;
  assign out_ch.valid  = out_valid_q;
  assign out_ch.status = out_status_q;
  assign out_ch.out_x  = out_x_q;
  assign out_ch.out_y  = out_y_q;
  assign out_ch.out_z  = out_z_q;

`ifndef SYNTHESIS
  a_mul_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == tac_pkg::S_MUL_WAIT))
    else $error("multiplier finished outside its wait state");

  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == tac_pkg::S_DIV_WAIT))
    else $error("divider finished outside its wait state");

  a_good_le_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    good_cnt <= taken_cnt)
    else $error("good sample count exceeds taken count");

  a_out_from_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == tac_pkg::S_RESULT))
    else $error("output register loaded outside the result state");
`endif

endmodule

`default_nettype wire
